// ----- rtl/core/rftm_pkg.sv -----
// Shared types and constants for the ranging frame trimmed-mean block.
package rftm_pkg;

  localparam int unsigned FrameLen  = 4;
  localparam int unsigned GroupLen  = 5;
  localparam int unsigned PosW      = $clog2(FrameLen);
  localparam int unsigned CountW    = 3;
  localparam int unsigned WinDepth  = GroupLen - 1;
  localparam int unsigned WinIdxW   = $clog2(WinDepth);
  localparam int unsigned DistW     = 16;
  localparam int unsigned SumW      = DistW + 3;
  localparam int unsigned TrimW     = DistW + 2;
  localparam int unsigned Div3Shift = 19;

  localparam logic [7:0]       HeaderByte = 8'hFF;
  localparam logic [CountW-1:0] LastCount = CountW'(GroupLen - 1);
  // ceil(2^19 / 3): exact floor division by three for operands below 2^19
  localparam logic [TrimW-1:0] Recip3     = TrimW'(174763);

  typedef enum logic {
    ACT_BYTE    = 1'b0,
    ACT_MEASURE = 1'b1
  } action_e;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic             frame_ok;
  } reading_t;

  typedef struct packed {
    logic [DistW-1:0] avg_distance;
    logic             avg_valid;
  } average_t;

endpackage

// ----- rtl/core/ranging_frame_trimmed_mean.sv -----
// A request's result is registered and offered in the cycle after its transfer.
// Throughput: one item per cycle; a byte transfer yields no result.
// The output register is refilled in the cycle it is taken, so input stalls only
// while a result waits unclaimed. Reset clears frame buffer, position, ready flag,
// group count and output valid; the reading window needs no reset.
// Top level of the ranging frame receiver with trimmed mean of five readings.
module ranging_frame_trimmed_mean (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic [0:0]  s_axis_tuser_i,   // [0] action
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [15:0] distance, [31:16] avg_distance
  output logic [1:0]  m_axis_tuser_o    // [0] frame_ok, [1] avg_valid
);

  logic               in_xfer;
  logic               byte_we;
  logic               meas_re;
  rftm_pkg::reading_t reading;
  rftm_pkg::average_t average;
  logic               out_valid_q, out_valid_d;
  logic [31:0]        out_data_q;
  logic [1:0]         out_user_q;

  // Accept while the output register is empty or being taken
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_xfer = s_axis_tvalid_i && s_axis_tready_o;
  assign byte_we = in_xfer && (rftm_pkg::action_e'(s_axis_tuser_i[0]) == rftm_pkg::ACT_BYTE);
  assign meas_re = in_xfer &&
                   (rftm_pkg::action_e'(s_axis_tuser_i[0]) == rftm_pkg::ACT_MEASURE);

  rftm_frame_rx u_frame_rx (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_we_i (byte_we),
    .meas_re_i (meas_re),
    .rx_byte_i (s_axis_tdata_i),
    .reading_o (reading)
  );

  rftm_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .meas_re_i (meas_re),
    .reading_i (reading.distance),
    .average_o (average)
  );

  // Track output valid: set by a request, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (meas_re) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Load the result payload on a request
  always_ff @(posedge clk_i) begin
    if (meas_re) begin
      out_data_q <= {average.avg_distance, reading.distance};
      out_user_q <= {average.avg_valid, reading.frame_ok};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

// ----- rtl/core/rftm_frame_rx.sv -----
// Frame buffer, byte position and ready flag; decodes one reading per request.
module rftm_frame_rx (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 byte_we_i,
  input  logic                 meas_re_i,
  input  logic [7:0]           rx_byte_i,
  output rftm_pkg::reading_t   reading_o
);

  logic [7:0]                  frame_q [rftm_pkg::FrameLen];
  logic [rftm_pkg::PosW-1:0]   pos_q;
  logic                        ready_q;
  logic                        good;
  logic [7:0]                  csum;

  // Check header and checksum of the held frame
  always_comb begin
    csum = frame_q[1] + frame_q[2];
    good = ready_q && (frame_q[0] == rftm_pkg::HeaderByte) && (csum == frame_q[3]);
    reading_o.frame_ok = good;
    reading_o.distance = good ? {frame_q[1], frame_q[2]} : '0;
  end

  // Store bytes, flag a full frame, drop the flag on a request, clear a consumed good frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rftm_pkg::FrameLen; i++) frame_q[i] <= '0;
      pos_q   <= '0;
      ready_q <= 1'b0;
    end else if (byte_we_i) begin
      frame_q[pos_q] <= rx_byte_i;
      if (pos_q == rftm_pkg::PosW'(rftm_pkg::FrameLen - 1)) ready_q <= 1'b1;
      pos_q <= pos_q + 1'b1;
    end else if (meas_re_i) begin
      ready_q <= 1'b0;
      if (good) begin
        for (int i = 0; i < rftm_pkg::FrameLen; i++) frame_q[i] <= '0;
      end
    end
  end

endmodule

// ----- rtl/core/rftm_window.sv -----
// Reading window, group counter and trimmed mean of five readings.
module rftm_window (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          meas_re_i,
  input  logic [rftm_pkg::DistW-1:0]    reading_i,
  output rftm_pkg::average_t            average_o
);

  logic [rftm_pkg::DistW-1:0]   win_q [rftm_pkg::WinDepth];
  logic [rftm_pkg::CountW-1:0]  count_q;
  logic                         last;
  logic [rftm_pkg::DistW-1:0]   lo01, hi01, lo23, hi23, lo_a, hi_a, min_v, max_v;
  logic [rftm_pkg::SumW-1:0]    sum5;
  logic [rftm_pkg::TrimW-1:0]   trim;
  logic [2*rftm_pkg::TrimW-1:0] prod;

  assign last = (count_q >= rftm_pkg::LastCount);

  // Find minimum and maximum of the five readings
  always_comb begin
    lo01  = (win_q[0] < win_q[1]) ? win_q[0] : win_q[1];
    hi01  = (win_q[0] < win_q[1]) ? win_q[1] : win_q[0];
    lo23  = (win_q[2] < win_q[3]) ? win_q[2] : win_q[3];
    hi23  = (win_q[2] < win_q[3]) ? win_q[3] : win_q[2];
    lo_a  = (lo01 < lo23) ? lo01 : lo23;
    hi_a  = (hi01 > hi23) ? hi01 : hi23;
    min_v = (lo_a < reading_i) ? lo_a : reading_i;
    max_v = (hi_a > reading_i) ? hi_a : reading_i;
  end

  // Sum the middle three and divide by three through the reciprocal
  always_comb begin
    sum5 = rftm_pkg::SumW'(win_q[0]) + rftm_pkg::SumW'(win_q[1])
         + rftm_pkg::SumW'(win_q[2]) + rftm_pkg::SumW'(win_q[3])
         + rftm_pkg::SumW'(reading_i);
    trim = rftm_pkg::TrimW'(sum5 - rftm_pkg::SumW'(min_v) - rftm_pkg::SumW'(max_v));
    prod = (2*rftm_pkg::TrimW)'(trim) * (2*rftm_pkg::TrimW)'(rftm_pkg::Recip3);
    average_o.avg_valid    = last;
    average_o.avg_distance = last ?
        prod[rftm_pkg::Div3Shift +: rftm_pkg::DistW] : '0;
  end

  // Hold readings of the group
  always_ff @(posedge clk_i) begin
    if (meas_re_i && !last) win_q[count_q[rftm_pkg::WinIdxW-1:0]] <= reading_i;
  end

  // Advance the group counter, wrap on the fifth request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (meas_re_i) begin
      count_q <= last ? '0 : count_q + 1'b1;
    end
  end

endmodule
